// ----- design/trd_pkg.sv -----
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants for the TGA run-length pixel decoder
// Configuration register indexes, port widths and pixel byte phases.
// ----------------------------------------------------------------------------
package trd_pkg;

	// Widths of the fixed port fields
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CIDX_W  = 2;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_HAS_ALPHA    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

	// Position of the next byte inside a stored pixel (blue, green, red, alpha)
	typedef enum logic [1:0] {
		PH_BLUE  = 2'd0,
		PH_GREEN = 2'd1,
		PH_RED   = 2'd2,
		PH_ALPHA = 2'd3
	} phase_t;

	// Largest repeat count a run packet can carry
	localparam logic [BYTE_W-1:0] MAX_RUN = 8'd128;

endpackage

// ----- design/tga_rle_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder: run-length TGA pixel-data decoder
// Parses packet headers and BGR(A) bytes, emits one RGB pixel with a repeat
// count per stored pixel and flags the pixel that completes the image.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | data_byte
//  out     | out_valid / out_stall | red, green, blue, repeat_count,
//          |                       | last_of_image
//  cfg     | cfg_write             | cfg_index, cfg_data
//
//  One byte per cycle sustained unless out stalls. A byte sits in the input
//  register while decode logic works on it, and a pixel moves into the output
//  register as its last byte leaves. The image-size product is registered on
//  the config write, so the per-byte path is one wide compare and subtract.
//  Reset clears all control state and returns the config to 0 / 1 / 1.
//  in_stall rises only while the output register holds an untaken pixel and
//  the input register holds a byte waiting for it.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
	parameter int unsigned DIM_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_write,
	input  logic [trd_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [trd_pkg::CFG_W-1:0]         cfg_data,
	// byte input
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [trd_pkg::BYTE_W-1:0]        data_byte,
	// pixel output
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [trd_pkg::BYTE_W-1:0]        red,
	output logic [trd_pkg::BYTE_W-1:0]        green,
	output logic [trd_pkg::BYTE_W-1:0]        blue,
	output logic [trd_pkg::BYTE_W-1:0]        repeat_count,
	output logic                              last_of_image
);

	localparam int unsigned TW = 2 * DIM_BITS;
	localparam int unsigned BW = trd_pkg::BYTE_W;

	// Configuration registers and image size product
	logic                have_alpha_q;
	logic [DIM_BITS-1:0] width_q;
	logic [DIM_BITS-1:0] height_q;
	logic [TW-1:0]       total_q;
	logic [DIM_BITS-1:0] mul_a;
	logic [DIM_BITS-1:0] mul_b;
	logic [TW-1:0]       mul_p;

	// Input register
	logic          byte_vld_s1;
	logic [BW-1:0] byte_s1;
	logic          advance;

	// Decoder state
	logic              expect_hdr_q;
	logic              run_pkt_q;
	logic [BW-1:0]     left_q;
	trd_pkg::phase_t   phase_q;
	logic [BW-1:0]     blue_q;
	logic [BW-1:0]     green_q;
	logic [BW-1:0]     red_q;
	logic [TW-1:0]     done_q;

	// Output register
	logic          out_vld_q;
	logic [BW-1:0] red_q_o;
	logic [BW-1:0] green_q_o;
	logic [BW-1:0] blue_q_o;
	logic [BW-1:0] count_q;
	logic          last_q;

	// Decode logic
	logic          emit;
	logic [BW-1:0] emit_red;
	logic [BW-1:0] want;
	logic [TW-1:0] remain;
	logic          past_end;
	logic          clip;
	logic [BW-1:0] count;
	logic          is_last;
	logic [BW-1:0] left_dec;

	// Product operands: new value against the stored other dimension
	always_comb begin
		if (cfg_index == trd_pkg::CFG_IMAGE_WIDTH) begin
			mul_a = cfg_data[DIM_BITS-1:0];
			mul_b = height_q;
		end else begin
			mul_a = width_q;
			mul_b = cfg_data[DIM_BITS-1:0];
		end
		mul_p = TW'(mul_a) * TW'(mul_b);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_alpha_q <= 1'b0;
			width_q      <= DIM_BITS'(1);
			height_q     <= DIM_BITS'(1);
			total_q      <= TW'(1);
		end else if (cfg_write) begin
			if (cfg_index == trd_pkg::CFG_HAS_ALPHA) begin
				have_alpha_q <= cfg_data[0];
			end
			if (cfg_index == trd_pkg::CFG_IMAGE_WIDTH) begin
				width_q <= cfg_data[DIM_BITS-1:0];
				total_q <= mul_p;
			end
			if (cfg_index == trd_pkg::CFG_IMAGE_HEIGHT) begin
				height_q <= cfg_data[DIM_BITS-1:0];
				total_q  <= mul_p;
			end
		end
	end

	// Input register moves on whenever the output register can take a pixel
	assign advance  = !out_vld_q || !out_stall;
	assign in_stall = byte_vld_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			byte_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	// Pixel completes on the red byte without alpha, or on the alpha byte
	always_comb begin
		emit = !expect_hdr_q &&
			((phase_q == trd_pkg::PH_RED && !have_alpha_q) ||
			 (phase_q == trd_pkg::PH_ALPHA));
		emit_red = (phase_q == trd_pkg::PH_RED) ? byte_s1 : red_q;
	end

	// Repeat count, clipped to the pixels left in the image
	always_comb begin
		if (run_pkt_q && left_q != '0) begin
			want = left_q;
		end else begin
			want = BW'(1);
		end
		past_end = done_q >= total_q;
		remain   = total_q - done_q;
		clip     = TW'(want) >= remain;
		if (past_end) begin
			count = BW'(1);
		end else if (clip) begin
			count = remain[BW-1:0];
		end else begin
			count = want;
		end
		is_last  = past_end || clip;
		left_dec = left_q - BW'(1);
	end

	// Decoder state update, one byte per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_hdr_q <= 1'b1;
			run_pkt_q    <= 1'b0;
			left_q       <= '0;
			phase_q      <= trd_pkg::PH_BLUE;
			blue_q       <= '0;
			green_q      <= '0;
			red_q        <= '0;
			done_q       <= '0;
		end else if (byte_vld_s1 && advance) begin
			if (expect_hdr_q) begin
				// both packet kinds carry a count of the low seven bits plus one
				run_pkt_q    <= byte_s1[BW-1];
				left_q       <= {1'b0, byte_s1[BW-2:0]} + BW'(1);
				expect_hdr_q <= 1'b0;
				phase_q      <= trd_pkg::PH_BLUE;
			end else begin
				unique case (phase_q)
					trd_pkg::PH_BLUE: begin
						blue_q  <= byte_s1;
						phase_q <= trd_pkg::PH_GREEN;
					end
					trd_pkg::PH_GREEN: begin
						green_q <= byte_s1;
						phase_q <= trd_pkg::PH_RED;
					end
					trd_pkg::PH_RED: begin
						red_q <= byte_s1;
						if (have_alpha_q) begin
							phase_q <= trd_pkg::PH_ALPHA;
						end
					end
					trd_pkg::PH_ALPHA: begin
					end
					default: begin
					end
				endcase
				if (emit) begin
					phase_q <= trd_pkg::PH_BLUE;
					if (is_last) begin
						done_q       <= '0;
						expect_hdr_q <= 1'b1;
						left_q       <= '0;
					end else begin
						done_q <= done_q + TW'(count);
						if (run_pkt_q) begin
							left_q       <= '0;
							expect_hdr_q <= 1'b1;
						end else begin
							left_q       <= left_dec;
							expect_hdr_q <= (left_dec == '0);
						end
					end
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= byte_vld_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && byte_vld_s1 && emit) begin
			red_q_o   <= emit_red;
			green_q_o <= green_q;
			blue_q_o  <= blue_q;
			count_q   <= count;
			last_q    <= is_last;
		end
	end

	assign out_valid     = out_vld_q;
	assign red           = red_q_o;
	assign green         = green_q_o;
	assign blue          = blue_q_o;
	assign repeat_count  = count_q;
	assign last_of_image = last_q;

endmodule

// ----- design/trd_checker.sv -----
// ----------------------------------------------------------------------------
// trd_checker: port-level checks for the TGA run-length pixel decoder
// Watches the handshakes and result fields and reports violations.
// ----------------------------------------------------------------------------
module trd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [trd_pkg::BYTE_W-1:0]  red,
	input logic [trd_pkg::BYTE_W-1:0]  green,
	input logic [trd_pkg::BYTE_W-1:0]  blue,
	input logic [trd_pkg::BYTE_W-1:0]  repeat_count,
	input logic                        last_of_image
);

	// A stalled result transaction stays valid and unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green) &&
			$stable(blue) && $stable(repeat_count) && $stable(last_of_image))
		else $error("stalled output transaction changed");

	// Input backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");

	// Repeat count stays within one run packet
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> repeat_count != '0 && repeat_count <= trd_pkg::MAX_RUN)
		else $error("repeat count out of range");

	// A new result appears only after an input transaction has passed the input register
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a preceding input transaction");

endmodule

bind tga_rle_pixel_decoder trd_checker u_trd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.red           (red),
	.green         (green),
	.blue          (blue),
	.repeat_count  (repeat_count),
	.last_of_image (last_of_image)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for tga_rle_pixel_decoder
// A directed table walks the packet kinds, the byte extremes, clipped runs,
// image completion and mid-image register changes. Random packet streams
// under changing image settings follow. An in-bench decoder predicts each
// pixel, and every output transaction is checked field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned RANDOM_BYTES = 1750;
	localparam logic [trd_pkg::CIDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] count;
		logic       last;
	} pixel_t;

	typedef struct {
		bit          is_cfg;
		logic        alpha;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  data;
		bit          typed;
		pixel_t      want;
	} plan_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [trd_pkg::CIDX_W-1:0] cfg_index = '0;
	logic [trd_pkg::CFG_W-1:0]  cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [trd_pkg::BYTE_W-1:0] data_byte = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [trd_pkg::BYTE_W-1:0] red, green, blue, repeat_count;
	logic                       last_of_image;

	// Predicted decoder state and image settings
	logic            img_alpha;
	logic [15:0]     img_w, img_h;
	logic            awaiting_header, in_run;
	logic [7:0]      packet_left;
	trd_pkg::phase_t phase;
	logic [7:0]      px_r, px_g, px_b;
	logic [31:0]     done_cnt;

	pixel_t    pending_pixels[$];
	plan_row_t plan[$];

	bit  send_gaps, recv_stalls;
	int  stall_left;
	int  quiet_cycles;
	int  fail_count, bytes_sent, pixels_checked, cfg_writes;

	tga_rle_pixel_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue),
		.repeat_count(repeat_count), .last_of_image(last_of_image)
	);

	always #5 clk = ~clk;

	// Finish the held pixel: clip to what is left of the image, advance counters
	function automatic pixel_t emit_pixel();
		logic [31:0] total, want, count, remain;
		logic        last;
		pixel_t      px;
		total = 32'(img_w) * 32'(img_h);
		want = in_run ? 32'(packet_left) : 32'd1;
		if (want == 0)
			want = 1;
		last = 1'b0;
		if (done_cnt >= total) begin
			count = 1;
			last = 1'b1;
		end else begin
			remain = total - done_cnt;
			count = want;
			if (count >= remain) begin
				count = remain;
				last = 1'b1;
			end
		end
		px.red = px_r;
		px.green = px_g;
		px.blue = px_b;
		px.count = count[7:0];
		px.last = last;
		phase = trd_pkg::PH_BLUE;
		if (last) begin
			done_cnt = 0;
			awaiting_header = 1'b1;
			packet_left = 0;
		end else begin
			done_cnt += count;
			if (in_run) begin
				packet_left = 0;
				awaiting_header = 1'b1;
			end else begin
				packet_left -= 1;
				if (packet_left == 0)
					awaiting_header = 1'b1;
			end
		end
		return px;
	endfunction

	// Advance the predicted decoder by one byte; got is set when a pixel results
	function automatic void decode_byte(input logic [7:0] b, output bit got, output pixel_t px);
		got = 1'b0;
		px = '0;
		if (awaiting_header) begin
			in_run = (b >= trd_pkg::MAX_RUN);
			packet_left = in_run ? b - (trd_pkg::MAX_RUN - 8'd1) : b + 8'd1;
			awaiting_header = 1'b0;
			phase = trd_pkg::PH_BLUE;
		end else begin
			case (phase)
				trd_pkg::PH_BLUE: begin
					px_b = b;
					phase = trd_pkg::PH_GREEN;
				end
				trd_pkg::PH_GREEN: begin
					px_g = b;
					phase = trd_pkg::PH_RED;
				end
				trd_pkg::PH_RED: begin
					px_r = b;
					if (img_alpha)
						phase = trd_pkg::PH_ALPHA;
					else begin
						px = emit_pixel();
						got = 1'b1;
					end
				end
				default: begin
					// alpha byte is dropped, pixel completes
					px = emit_pixel();
					got = 1'b1;
				end
			endcase
		end
	endfunction

	function automatic plan_row_t byte_row(input logic [7:0] d);
		plan_row_t r;
		r = '{default: '0};
		r.data = d;
		return r;
	endfunction

	function automatic plan_row_t pixel_row(input logic [7:0] d, input logic [7:0] rr, gg, bb,
			input logic [7:0] cnt, input logic last);
		plan_row_t r;
		r = byte_row(d);
		r.typed = 1'b1;
		r.want = '{red: rr, green: gg, blue: bb, count: cnt, last: last};
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic a, input logic [15:0] w, h);
		plan_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.alpha = a;
		r.w = w;
		r.h = h;
		return r;
	endfunction

	// One byte transaction, with an optional sender gap first
	task automatic push_byte(input logic [7:0] b, input bit typed, input pixel_t want);
		bit     got;
		pixel_t px;
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		decode_byte(b, got, px);
		if (typed)
			pending_pixels.push_back(want);
		else if (got)
			pending_pixels.push_back(px);
		bytes_sent++;
	endtask

	// Hold the sender until every pixel is out and the pipeline has emptied
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_image(input logic alpha, input logic [15:0] w, h, input bit junk);
		cfg_write <= 1'b1;
		cfg_index <= trd_pkg::CFG_HAS_ALPHA;
		cfg_data <= {15'd0, alpha};
		@(posedge clk);
		cfg_index <= trd_pkg::CFG_IMAGE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= trd_pkg::CFG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		// unmapped index must be ignored
		if (junk) begin
			cfg_index <= CFG_UNUSED;
			cfg_data <= 16'($urandom);
			@(posedge clk);
		end
		cfg_write <= 1'b0;
		img_alpha = alpha;
		img_w = w;
		img_h = h;
		cfg_writes++;
	endtask

	// Mostly well-formed packets with random content, some noise and truncation
	task automatic run_phase(input int n);
		int          start, npix, nbytes;
		logic [7:0]  hdr;
		start = bytes_sent;
		while (bytes_sent - start < n) begin
			if ($urandom_range(0, 9) == 0)
				push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
			else begin
				if ($urandom_range(0, 7) == 0)
					hdr = 8'($urandom_range(0, 255));
				else if ($urandom_range(0, 1) == 1)
					hdr = 8'($urandom_range(0, 7));
				else
					hdr = trd_pkg::MAX_RUN + 8'($urandom_range(0, 7));
				npix = (hdr < trd_pkg::MAX_RUN) ? int'(hdr) + 1 : 1;
				nbytes = npix * (img_alpha ? 4 : 3);
				if ($urandom_range(0, 19) == 0)
					nbytes = $urandom_range(0, nbytes - 1);
				push_byte(hdr, 1'b0, '0);
				repeat (nbytes) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
			end
		end
	endtask

	// Receiver stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 12);
		end else
			out_stall <= 1'b0;
	end

	task automatic check_field(input string name, input logic [7:0] exp, act);
		if (exp !== act) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, exp, act);
			fail_count++;
		end
	endtask

	// Pixel checker
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			pixels_checked++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel r=%h g=%h b=%h count=%0d last=%b", $time,
					red, green, blue, repeat_count, last_of_image);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("repeat_count", want.count, repeat_count);
				check_field("last_of_image", {7'd0, want.last}, {7'd0, last_of_image});
			end
		end
	end

	// Watchdog: cycles with no transaction of any kind
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: timeout, %0d pixels still expected", $time, pending_pixels.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int        sel, rnd_start;
		logic      a;
		logic [15:0] w, h;
		bit        last_stretch;

		img_alpha = 1'b0;
		img_w = 16'd1;
		img_h = 16'd1;
		awaiting_header = 1'b1;
		in_run = 1'b0;
		packet_left = '0;
		phase = trd_pkg::PH_BLUE;
		{px_r, px_g, px_b} = '0;
		done_cnt = '0;
		send_gaps = 1'b1;
		recv_stalls = 1'b1;
		stall_left = 0;
		quiet_cycles = 0;

		// Reset config is no alpha, 1x1: raw packet of three ends after one pixel
		plan.push_back(byte_row(8'h02));
		plan.push_back(byte_row(8'h11));
		plan.push_back(byte_row(8'h22));
		plan.push_back(pixel_row(8'h33, 8'h33, 8'h22, 8'h11, 8'd1, 1'b1));
		// longest run, clipped to the single pixel left
		plan.push_back(byte_row(8'hFF));
		plan.push_back(byte_row(8'hFF));
		plan.push_back(byte_row(8'h00));
		plan.push_back(pixel_row(8'h80, 8'h80, 8'h00, 8'hFF, 8'd1, 1'b1));
		// largest image with alpha; alpha cleared while the alpha byte is pending
		plan.push_back(cfg_row(1'b1, 16'hFFFF, 16'hFFFF));
		plan.push_back(byte_row(8'hFF));
		plan.push_back(byte_row(8'h01));
		plan.push_back(byte_row(8'h02));
		plan.push_back(byte_row(8'h03));
		plan.push_back(cfg_row(1'b0, 16'hFFFF, 16'hFFFF));
		plan.push_back(pixel_row(8'hEE, 8'h03, 8'h02, 8'h01, 8'd128, 1'b0));
		plan.push_back(byte_row(8'h7F));
		plan.push_back(byte_row(8'h00));
		plan.push_back(byte_row(8'h00));
		plan.push_back(pixel_row(8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0));
		// image shrinks below the pixels already done
		plan.push_back(cfg_row(1'b0, 16'd1, 16'd1));
		plan.push_back(byte_row(8'hFF));
		plan.push_back(byte_row(8'hFF));
		plan.push_back(pixel_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1'b1));
		// zero height
		plan.push_back(cfg_row(1'b0, 16'd1, 16'd0));
		plan.push_back(byte_row(8'h85));
		plan.push_back(byte_row(8'h40));
		plan.push_back(byte_row(8'h41));
		plan.push_back(pixel_row(8'h42, 8'h42, 8'h41, 8'h40, 8'd1, 1'b1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain_pipeline();
				set_image(plan[i].alpha, plan[i].w, plan[i].h, 1'b1);
			end else
				push_byte(plan[i].data, plan[i].typed, plan[i].want);
		end

		// Random phases, each under a fresh or partly kept image setting
		rnd_start = bytes_sent;
		while (bytes_sent - rnd_start < RANDOM_BYTES) begin
			last_stretch = (bytes_sent - rnd_start) > (RANDOM_BYTES * 85 / 100);
			drain_pipeline();
			send_gaps = !last_stretch && $urandom_range(0, 3) != 0;
			recv_stalls = !last_stretch && $urandom_range(0, 3) != 0;
			sel = $urandom_range(0, 19);
			a = 1'($urandom_range(0, 1));
			w = 16'($urandom_range(1, 16));
			h = 16'($urandom_range(1, 8));
			case (sel)
				0: begin
					if ($urandom_range(0, 1) == 1)
						w = 16'd0;
					else
						h = 16'd0;
				end
				1: begin
					w = 16'hFFFF;
					h = 16'hFFFF;
				end
				2: begin
					w = 16'($urandom_range(0, 65535));
					h = 16'($urandom_range(0, 65535));
				end
				3: begin
					// keep the image, change only the pixel format
					w = img_w;
					h = img_h;
				end
				4: begin
					w = 16'($urandom_range(1, 3));
					h = 16'($urandom_range(1, 3));
				end
				default: ;
			endcase
			set_image(a, w, h, $urandom_range(0, 9) == 0);
			run_phase($urandom_range(20, 120));
		end

		drain_pipeline();
		repeat (8) @(posedge clk);
		$display("Sent %0d bytes over %0d image settings, checked %0d pixels", bytes_sent,
			cfg_writes, pixels_checked);
		$display("Covered raw and run packets, clipping, zero and full size, mid-image changes");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
